FILE: rtl/rotation_matrix_to_euler_angles_core_assert.svh
// Assertion macros shared by the RTL.
`ifndef ROTATION_MATRIX_TO_EULER_ANGLES_CORE_ASSERT_SVH
`define ROTATION_MATRIX_TO_EULER_ANGLES_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RMTE_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define RMTE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define RMTE_ASSERT_IMPL(name, clk, rst, ante, cons)
`define RMTE_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/rmte_pkg.sv
`timescale 1ns / 1ps
package rmte_pkg;

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
   } req_type;

   typedef struct packed {
      logic signed [23:0] roll;
      logic signed [23:0] pitch;
      logic signed [23:0] yaw;
      logic               gimbal_lock;
   } rsp_type;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 23;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_DEGREES   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEGREE_SCALE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GIMBAL_THRESHOLD = 2'd2;

   localparam logic [22:0] DEGREE_SCALE_RESET = 23'd3754936;

   // operand, vector and angle widths
   localparam int OP_W  = 17;
   localparam int VEC_W = 36;
   localparam int ANG_W = 34;
   localparam int OUT_W = 24;

   localparam logic [31:0] PI_Q30 = 32'd3373259426;
   localparam int signed RAD_LIMIT = 25800;

   // atan(2^-i), 2^32 per turn
   localparam logic [31:0] ATAN_TAB [0:23] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

endpackage

FILE: rtl/rmte_angle.sv
`timescale 1ns / 1ps
module rmte_angle #(
   parameter int STEPS = 16
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [rmte_pkg::OP_W-1:0]  y_in,
   input  logic signed [rmte_pkg::OP_W-1:0]  x_in,
   input  logic                              output_degrees,
   input  logic [22:0]                       degree_scale,
   output logic signed [rmte_pkg::OUT_W-1:0] angle
);
   import rmte_pkg::*;

   logic signed [VEC_W-1:0] x_ff [0:STEPS];
   logic signed [VEC_W-1:0] y_ff [0:STEPS];
   logic signed [ANG_W-1:0] z_ff [0:STEPS];
   logic                    zf_ff [0:STEPS];

   logic signed [VEC_W-1:0] xp;
   logic signed [VEC_W-1:0] yp;

   assign xp = VEC_W'(x_in) <<< 16;
   assign yp = VEC_W'(y_in) <<< 16;

   // prep: fold the left half plane onto the right
   always_ff @(posedge clock) begin
      if (en) begin
         zf_ff[0] <= (x_in == '0) && (y_in == '0);
         if (x_in < 0) begin
            x_ff[0] <= -xp;
            y_ff[0] <= -yp;
            z_ff[0] <= (y_in >= 0) ? (ANG_W'(1) <<< 31) : -(ANG_W'(1) <<< 31);
         end else begin
            x_ff[0] <= xp;
            y_ff[0] <= yp;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [VEC_W-1:0] xs;
      logic signed [VEC_W-1:0] ys;
      logic signed [ANG_W-1:0] da;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      assign da = ANG_W'(ATAN_TAB[i]);
      always_ff @(posedge clock) begin
         if (en) begin
            zf_ff[i+1] <= zf_ff[i];
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + da;
            end else begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - da;
            end
         end
      end
   end

   // scale to Q10.13 radians, then optionally to degrees
   logic signed [ANG_W-1:0] zf;
   logic [32:0]             mag;
   logic                    neg_in;
   logic [47:0]             lo_ff;
   logic [48:0]             hi_ff;
   logic                    neg1_ff;

   assign zf     = z_ff[STEPS];
   assign neg_in = (zf < 0) && !zf_ff[STEPS];
   assign mag    = zf_ff[STEPS] ? '0 : ((zf < 0) ? 33'(-zf) : 33'(zf));

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff   <= 48'(mag[15:0]) * 48'(PI_Q30);
         hi_ff   <= 49'(mag[32:16]) * 49'(PI_Q30);
         neg1_ff <= neg_in;
      end
   end

   logic [65:0] full;
   logic [17:0] r_ff;
   logic        neg2_ff;

   assign full = {1'b0, hi_ff, 16'b0} + {18'b0, lo_ff} + (66'd1 << 47);

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff    <= full[65:48];
         neg2_ff <= neg1_ff;
      end
   end

   logic [40:0] p_ff;
   logic        neg3_ff;
   logic        deg3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff    <= output_degrees ? 41'(r_ff) * 41'(degree_scale) : 41'(r_ff);
         neg3_ff <= neg2_ff;
         deg3_ff <= output_degrees;
      end
   end

   logic [41:0]       rnd;
   logic [25:0]       mag4;
   logic [OUT_W-1:0]  sm;
   logic [OUT_W-1:0]  out_in;
   logic [OUT_W-1:0]  out_ff;

   assign rnd  = ({1'b0, p_ff} + 42'd32768) >> 16;
   assign mag4 = deg3_ff ? rnd[25:0] : p_ff[25:0];
   assign sm   = (mag4 > 26'd8388608) ? 24'd8388608 : mag4[OUT_W-1:0];

   always_comb begin
      if (neg3_ff) begin
         out_in = -sm;
      end else if (sm[OUT_W-1]) begin
         out_in = 24'd8388607;
      end else begin
         out_in = sm;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign angle = $signed(out_ff);

endmodule

FILE: rtl/rotation_matrix_to_euler_angles_core.sv
`timescale 1ns / 1ps
`include "rotation_matrix_to_euler_angles_core_assert.svh"
// Channel  Ports                           Moves
// req      req_valid/req_ready/req_data    one matrix item (seven Q2.14 entries)
// rsp      rsp_valid/rsp_ready/rsp_data    roll, pitch, yaw (Q10.13) and lock flag
// csr      csr_we/csr_index/csr_wdata      register write, no wait
// One item per cycle while rsp is not stalled. The pipe holds squaring, a 16-stage
// bit-pair square root, a prep stage, one CORDIC stage per step and four
// scaling stages. The whole pipe advances together when the output register
// is empty or taken, so a stall on rsp holds every stage in place.
// Synchronous reset clears valid bits and the CSR registers, no clearing pass.
module rotation_matrix_to_euler_angles_core #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rmte_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rmte_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [rmte_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rmte_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rmte_pkg::*;

   localparam int SQ_STAGES = 16;
   localparam int ANG_LAT   = CORDIC_STEPS + 5;

   logic        deg_ff;
   logic [22:0] scale_ff;
   logic [14:0] thr_ff;
   logic        adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         deg_ff   <= 1'b0;
         scale_ff <= DEGREE_SCALE_RESET;
         thr_ff   <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_OUTPUT_DEGREES) begin
            deg_ff <= csr_wdata[0];
         end
         if (csr_index == CSR_DEGREE_SCALE) begin
            scale_ff <= csr_wdata[22:0];
         end
         if (csr_index == CSR_GIMBAL_THRESHOLD) begin
            thr_ff <= csr_wdata[14:0];
         end
      end
   end

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // squaring stage and square root pipe
   logic        sv_ff   [0:SQ_STAGES];
   logic [17:0] rem_ff  [0:SQ_STAGES];
   logic [15:0] root_ff [0:SQ_STAGES];
   logic [31:0] rad_ff  [0:SQ_STAGES];
   req_type     item_ff [0:SQ_STAGES];

   logic signed [31:0] p21;
   logic signed [31:0] p22;

   assign p21 = 32'(req_data.m21) * 32'(req_data.m21);
   assign p22 = 32'(req_data.m22) * 32'(req_data.m22);

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else if (adv) begin
         sv_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         rad_ff[0]  <= unsigned'(p21) + unsigned'(p22);
         item_ff[0] <= req_data;
      end
   end

   for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
      logic [19:0] cand;
      logic [19:0] trial;
      logic [19:0] diff;
      logic        ge;
      assign cand  = {rem_ff[k], rad_ff[k][31:30]};
      assign trial = {2'b00, root_ff[k], 2'b01};
      assign diff  = cand - trial;
      assign ge    = cand >= trial;
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sv_ff[k+1] <= sv_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k+1]  <= ge ? diff[17:0] : cand[17:0];
            root_ff[k+1] <= {root_ff[k][14:0], ge};
            rad_ff[k+1]  <= rad_ff[k] << 2;
            item_ff[k+1] <= item_ff[k];
         end
      end
   end

   // branch select
   req_type                 mi;
   logic [15:0]             sy;
   logic                    lock;
   logic signed [OP_W-1:0]  roll_y, roll_x, pitch_y, pitch_x, yaw_y, yaw_x;

   assign mi      = item_ff[SQ_STAGES];
   assign sy      = root_ff[SQ_STAGES];
   assign lock    = sy <= {1'b0, thr_ff};
   assign pitch_y = -OP_W'(mi.m20);
   assign pitch_x = $signed({1'b0, sy});
   assign roll_y  = lock ? -OP_W'(mi.m12) : OP_W'(mi.m21);
   assign roll_x  = lock ? OP_W'(mi.m11) : OP_W'(mi.m22);
   assign yaw_y   = OP_W'(mi.m10);
   assign yaw_x   = OP_W'(mi.m00);

   logic signed [OUT_W-1:0] roll_a, pitch_a, yaw_a;

   rmte_angle #(.STEPS(CORDIC_STEPS)) u_roll (
      .clock(clock), .en(adv), .y_in(roll_y), .x_in(roll_x),
      .output_degrees(deg_ff), .degree_scale(scale_ff), .angle(roll_a)
   );

   rmte_angle #(.STEPS(CORDIC_STEPS)) u_pitch (
      .clock(clock), .en(adv), .y_in(pitch_y), .x_in(pitch_x),
      .output_degrees(deg_ff), .degree_scale(scale_ff), .angle(pitch_a)
   );

   rmte_angle #(.STEPS(CORDIC_STEPS)) u_yaw (
      .clock(clock), .en(adv), .y_in(yaw_y), .x_in(yaw_x),
      .output_degrees(deg_ff), .degree_scale(scale_ff), .angle(yaw_a)
   );

   // valid and lock travel beside the angle units
   logic av_ff [0:ANG_LAT-1];
   logic al_ff [0:ANG_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         av_ff[0] <= 1'b0;
      end else if (adv) begin
         av_ff[0] <= sv_ff[SQ_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         al_ff[0] <= lock;
      end
   end

   for (genvar j = 1; j < ANG_LAT; j++) begin : g_dly
      always_ff @(posedge clock) begin
         if (reset) begin
            av_ff[j] <= 1'b0;
         end else if (adv) begin
            av_ff[j] <= av_ff[j-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            al_ff[j] <= al_ff[j-1];
         end
      end
   end

   assign rsp_valid            = av_ff[ANG_LAT-1];
   assign rsp_data.roll        = roll_a;
   assign rsp_data.pitch       = pitch_a;
   assign rsp_data.yaw         = al_ff[ANG_LAT-1] ? '0 : yaw_a;
   assign rsp_data.gimbal_lock = al_ff[ANG_LAT-1];

   `RMTE_ASSERT_IMPL(a_stall_only_downstream, clock, reset, !req_ready, rsp_valid)
   `RMTE_ASSERT_IMPL(a_lock_yaw_zero, clock, reset, rsp_valid && rsp_data.gimbal_lock, rsp_data.yaw == '0)
   `RMTE_ASSERT_IMPL(a_rad_range, clock, reset, rsp_valid && !deg_ff, (rsp_data.roll <= RAD_LIMIT) && (rsp_data.roll >= -RAD_LIMIT))
   `RMTE_ASSERT_NEXT(a_item_enters_pipe, clock, reset, req_valid && req_ready, sv_ff[0])

endmodule
